// ===== rtl/core/kmp_pkg.sv =====
// Shared types and constants for the streaming KMP matcher.
`timescale 1ns / 1ps

package kmp_pkg;

    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 4;   // cell / failure-table index, covers 16 cells
    localparam int LEN_W     = 5;   // partial match length, 0..16
    localparam int POS_W     = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int PAT_W     = 2 * CFG_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } cfg_reg_t;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TEXT  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_SCAN,
        ST_EMIT
    } kmp_state_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic [BYTE_W-1:0] probe;
        logic [IDX_W-1:0]  eq_idx;
        logic [IDX_W-1:0]  fb_idx;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [IDX_W-1:0]  wr_val;
    } cell_ctrl_t;

    // Passed from cell to cell; the addressed cell substitutes its own values.
    typedef struct packed {
        logic             eq;
        logic [IDX_W-1:0] fail;
    } cell_chain_t;

endpackage

// ===== rtl/core/kmp_cell.sv =====
// One matcher cell: a pattern byte compare and one failure-table entry.
`timescale 1ns / 1ps

module kmp_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                       aclk,
    input  kmp_pkg::cell_ctrl_t        ctrl,
    input  logic [kmp_pkg::BYTE_W-1:0] pat_byte,
    input  kmp_pkg::cell_chain_t       chain_in,
    output kmp_pkg::cell_chain_t       chain_out
);
    import kmp_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [IDX_W-1:0] fail_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && (ctrl.wr_idx == MY_IDX)) begin
            fail_reg <= ctrl.wr_val;
        end
    end

    always_comb begin
        chain_out = chain_in;
        if (ctrl.eq_idx == MY_IDX) begin
            chain_out.eq = (pat_byte == ctrl.probe);
        end
        if (ctrl.fb_idx == MY_IDX) begin
            chain_out.fail = fail_reg;
        end
    end

endmodule

// ===== rtl/core/kmp_ctrl.sv =====
// Sequencer for failure-table build and text scan, plus result register.
`timescale 1ns / 1ps

module kmp_ctrl #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic [kmp_pkg::BYTE_W-1:0] s_text_byte,
    input  logic [kmp_pkg::PAT_W-1:0]  pattern,
    input  logic [kmp_pkg::LEN_W-1:0]  pattern_length,
    output kmp_pkg::cell_ctrl_t        cell_ctrl,
    input  kmp_pkg::cell_chain_t       cell_sel,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [kmp_pkg::POS_W-1:0]  m_match_start
);
    import kmp_pkg::*;

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_PATTERN);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    function automatic logic [BYTE_W-1:0] byte_at(input logic [PAT_W-1:0] p,
                                                  input logic [IDX_W-1:0] k);
        byte_at = p[{k, 3'b000} +: BYTE_W];
    endfunction

    kmp_state_t        state_reg, state_next;
    logic [LEN_W-1:0]  work_reg, work_next;    // partial match length / build len
    logic [LEN_W-1:0]  m_reg, m_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [BYTE_W-1:0] probe_reg, probe_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [POS_W-1:0]  match_reg, match_next;
    logic              valid_reg, valid_next;

    logic [LEN_W-1:0]  m_live;
    logic [LEN_W-1:0]  work_m1;
    logic [LEN_W-1:0]  adv;
    logic [LEN_W-1:0]  fbv;
    logic              fall;
    logic              hit;
    logic              i_last;
    logic              out_free;
    logic              wr_en_c;
    logic [IDX_W-1:0]  wr_idx_c;
    logic [IDX_W-1:0]  wr_val_c;

    assign m_live   = (pattern_length > LEN_CAP) ? LEN_CAP : pattern_length;
    assign work_m1  = work_reg - LEN_ONE;
    assign adv      = work_reg + LEN_W'(cell_sel.eq);
    assign fbv      = ({1'b0, cell_sel.fail} < work_reg) ? {1'b0, cell_sel.fail} : '0;
    assign fall     = (work_reg != '0) && !cell_sel.eq;
    assign hit      = (adv == m_reg);
    assign i_last   = ({1'b0, i_reg} == (m_reg - LEN_ONE));
    assign out_free = !valid_reg || m_ready;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = valid_reg;
    assign m_match_start = match_reg;

    assign cell_ctrl.probe  = probe_reg;
    assign cell_ctrl.eq_idx = work_reg[IDX_W-1:0];
    assign cell_ctrl.fb_idx = work_m1[IDX_W-1:0];
    assign cell_ctrl.wr_en  = wr_en_c;
    assign cell_ctrl.wr_idx = wr_idx_c;
    assign cell_ctrl.wr_val = wr_val_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            work_reg  <= '0;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            work_reg  <= work_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg     <= m_next;
        i_reg     <= i_next;
        probe_reg <= probe_next;
        start_reg <= start_next;
        match_reg <= match_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == FUNC_START) begin
                        if (m_live > LEN_ONE) state_next = ST_BUILD;
                    end else if (m_live != '0) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_BUILD: begin
                if (!fall && i_last) state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (!fall) state_next = hit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and cell writes
    always_comb begin
        work_next  = work_reg;
        m_next     = m_reg;
        i_next     = i_reg;
        probe_next = probe_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        match_next = match_reg;
        valid_next = valid_reg && !m_ready;
        wr_en_c    = 1'b0;
        wr_idx_c   = i_reg;
        wr_val_c   = adv[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    m_next = m_live;
                    if (s_func == FUNC_START) begin
                        pos_next   = '0;
                        work_next  = '0;
                        i_next     = IDX_W'(1);
                        probe_next = byte_at(pattern, IDX_W'(1));
                        // first table entry is always zero
                        wr_en_c    = (m_live != '0);
                        wr_idx_c   = '0;
                        wr_val_c   = '0;
                    end else begin
                        start_next = pos_reg;
                        pos_next   = pos_reg + POS_W'(1);
                        probe_next = s_text_byte;
                        if ((m_live == '0) || (work_reg >= m_live)) begin
                            work_next = '0;
                        end
                    end
                end
            end
            ST_BUILD: begin
                if (fall) begin
                    work_next = fbv;
                end else begin
                    wr_en_c = 1'b1;
                    if (i_last) begin
                        work_next = '0;
                    end else begin
                        work_next  = adv;
                        i_next     = i_reg + IDX_W'(1);
                        probe_next = byte_at(pattern, i_reg + IDX_W'(1));
                    end
                end
            end
            ST_SCAN: begin
                // on a full match hold length m so the next cycle reads entry m-1
                if (fall) work_next = fbv;
                else      work_next = adv;
            end
            ST_EMIT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    match_next = start_reg - POS_W'(m_reg) + POS_W'(1);
                    work_next  = fbv;
                end
            end
            default: begin
                work_next = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/kmp_stream_matcher_core.sv =====
// Top level of the streaming KMP matcher: configuration registers and cell row.
`timescale 1ns / 1ps

// Streaming Knuth-Morris-Pratt matcher for patterns of up to MAX_PATTERN bytes.
// Write the pattern bytes and length over the cfg port, then send a start
// transaction (s_func = 0) followed by text bytes (s_func = 1). A start of
// length 2 or more builds the failure table one entry at a time, with
// failure-chain steps taken between entries. A text byte is accepted, then
// compared, falling back along the failure chain until it matches or the
// length is zero; a completed match adds an emit step that stretches while an
// earlier result still waits on m_ready; the sequencer walks the chain one
// step per cycle through the row of pattern cells, one cell per pattern byte,
// each holding its failure entry. Each match yields one result transaction
// with the offset of its first byte modulo 2^32; overlapping matches are
// reported and length zero never matches. The failure table is not cleared by
// reset; send a start before the first text byte. Configuration may only be
// written while the block is idle.
module kmp_stream_matcher_core #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [kmp_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [kmp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [kmp_pkg::BYTE_W-1:0]    s_text_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kmp_pkg::POS_W-1:0]     m_match_start
);
    import kmp_pkg::*;

    logic [CFG_W-1:0] pat_low_reg;
    logic [CFG_W-1:0] pat_high_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic [PAT_W-1:0] pattern;

    cell_ctrl_t  cell_ctrl;
    cell_chain_t chain [MAX_PATTERN+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                CFG_PAT_HIGH: pat_high_reg <= cfg_wdata;
                CFG_PAT_LEN:  pat_len_reg  <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pattern  = {pat_high_reg, pat_low_reg};
    assign chain[0] = '0;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        kmp_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .pat_byte  (pattern[k*BYTE_W +: BYTE_W]),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1])
        );
    end

    kmp_ctrl #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_text_byte    (s_text_byte),
        .pattern        (pattern),
        .pattern_length (pat_len_reg),
        .cell_ctrl      (cell_ctrl),
        .cell_sel       (chain[MAX_PATTERN]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_start  (m_match_start)
    );

endmodule

// ===== rtl/core/kmp_chk.sv =====
// Port-level checks for the KMP matcher, bound to the top level.
`timescale 1ns / 1ps

module kmp_chk (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_func,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [kmp_pkg::POS_W-1:0]  m_match_start
);
    import kmp_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_match_start))
        else $error("result changed or dropped while stalled");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // a start transaction never produces a result
    a_start_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == FUNC_START) |=> !$rose(m_valid))
        else $error("result after start transaction");

    // results are issued only while the input side is busy
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result issued while idle");

endmodule

bind kmp_stream_matcher_core kmp_chk u_kmp_chk (.*);
